@@ src/mlf_pkg.sv @@
// Shared types and constants for the MAC learning forwarder.
// No dependencies; every other file of the block but mlf_ram imports this package.
package mlf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MAC_W   = 48;
    localparam int PORT_W  = 16;
    localparam int IP_W    = 32;
    localparam int ENTRY_W = MAC_W + PORT_W;

    // server count register and the round-robin remainder unit
    localparam int SC_W     = 9;
    localparam int REM_W    = SC_W + 1;
    localparam int RR_DIV_W = PORT_W + 1;
    localparam int STEP_W   = $clog2(RR_DIV_W + 1);

    localparam logic [SC_W-1:0]  SC_RESET  = SC_W'(4);
    localparam logic [MAC_W-1:0] MAC_BCAST = '1;

    // APB register map: register index is paddr[2]
    localparam int             APB_ADDR_W         = 3;
    localparam int             APB_DATA_W         = 32;
    localparam logic [0:0]     REG_SERVER_COUNT   = 1'b0;

    typedef struct packed {
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] ingress_port;
        logic [IP_W-1:0]   src_ipv4;
    } t_mlf_in;

    typedef struct packed {
        logic              flood;
        logic [PORT_W-1:0] egress_port;
        logic              learned_new;
        logic              table_full;
    } t_mlf_out;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic update;
        logic rr_take;
        logic load_out;
    } t_mlf_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic need_rr;
        logic rr_done;
        logic out_busy;
    } t_mlf_sts;

endpackage

@@ src/mlf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mlf_rem_unit.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on mlf_pkg.
module mlf_rem_unit
    import mlf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [RR_DIV_W-1:0] i_dividend,
    input  logic [SC_W-1:0]     i_divisor,
    output logic                o_busy,
    output logic [SC_W-1:0]     o_rem
);

    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic [RR_DIV_W-1:0] r_dvd;
    logic [REM_W-1:0]    r_rem;
    logic [SC_W-1:0]     r_dsr;
    logic [REM_W-1:0]    n_rem;
    logic [REM_W-1:0]    trial;

    // remainder stays below the divisor, so its low bits plus the next
    // dividend bit fit in REM_W bits
    always_comb begin
        trial = {r_rem[REM_W-2:0], r_dvd[RR_DIV_W-1]};
        if (trial >= REM_W'(r_dsr)) begin
            n_rem = trial - REM_W'(r_dsr);
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(RR_DIV_W);
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RR_DIV_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem[SC_W-1:0];

endmodule

@@ src/mlf_datapath.sv @@
// Datapath: item register, table scan, learn/insert, round-robin state, output register.
// Depends on mlf_pkg, mlf_ram and mlf_rem_unit.
module mlf_datapath
    import mlf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_mlf_cmd        i_cmd,
    output t_mlf_sts        o_sts,
    input  t_mlf_in         i_in_data,
    input  logic [SC_W-1:0] i_server_count,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output t_mlf_out        o_out_data
);

    t_mlf_in           r_item;
    logic [CNT_W-1:0]  r_scan_cnt;
    logic              r_rd_pend;
    logic              r_src_hit;
    logic              r_dst_hit;
    logic [PORT_W-1:0] r_dst_port;
    logic [CNT_W-1:0]  r_fill;
    logic [PORT_W-1:0] r_rr_last;
    logic              r_rr_started;
    t_mlf_out          r_res;
    t_mlf_out          r_out;
    logic              r_out_valid;

    logic [ENTRY_W-1:0] rdata;
    logic [MAC_W-1:0]   rd_key;
    logic [PORT_W-1:0]  rd_port;
    logic               tbl_full;
    logic               src_new;
    logic               learn;
    logic               is_bcast;
    logic               probe;
    logic               need_rr;
    logic               rem_start;
    logic               rem_busy;
    logic [SC_W-1:0]    rem_val;
    logic [SC_W-1:0]    divisor;
    t_mlf_out           n_res;

    assign rd_key  = rdata[ENTRY_W-1:PORT_W];
    assign rd_port = rdata[PORT_W-1:0];

    assign tbl_full = (r_fill == CNT_W'(TABLE_DEPTH));
    assign src_new  = !r_src_hit;
    assign learn    = src_new && !tbl_full;
    assign is_bcast = (r_item.dst_mac == MAC_BCAST);
    assign probe    = is_bcast && (r_item.src_ipv4 == '0);
    assign need_rr  = probe && r_rr_started;

    assign divisor   = (i_server_count == '0) ? SC_W'(1) : i_server_count;
    assign rem_start = i_cmd.update && need_rr;

    mlf_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.update && learn),
        .i_waddr(r_fill[IDX_W-1:0]),
        .i_wdata({r_item.src_mac, r_item.ingress_port}),
        .i_raddr(r_scan_cnt[IDX_W-1:0]),
        .o_rdata(rdata)
    );

    mlf_rem_unit u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rem_start),
        .i_dividend(RR_DIV_W'(r_rr_last) + RR_DIV_W'(1)),
        .i_divisor (divisor),
        .o_busy    (rem_busy),
        .o_rem     (rem_val)
    );

    // decision once both lookups are complete; the destination sees a
    // source learned by this very event
    always_comb begin
        n_res.flood       = 1'b1;
        n_res.egress_port = '0;
        n_res.learned_new = learn;
        n_res.table_full  = src_new && tbl_full;
        if (!is_bcast) begin
            if (r_dst_hit) begin
                n_res.flood       = 1'b0;
                n_res.egress_port = r_dst_port;
            end else if (learn && (r_item.dst_mac == r_item.src_mac)) begin
                n_res.flood       = 1'b0;
                n_res.egress_port = r_item.ingress_port;
            end
        end else if (probe) begin
            n_res.flood = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_rr_started <= 1'b0;
            r_rr_last    <= '0;
            r_rd_pend    <= 1'b0;
            r_scan_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_scan_cnt <= '0;
                r_rd_pend  <= 1'b0;
            end else if (i_cmd.scan) begin
                if (r_scan_cnt != r_fill) begin
                    r_scan_cnt <= r_scan_cnt + CNT_W'(1);
                    r_rd_pend  <= 1'b1;
                end else begin
                    r_rd_pend <= 1'b0;
                end
            end
            if (i_cmd.update) begin
                if (learn) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
                if (probe) begin
                    r_rr_started <= 1'b1;
                    if (!r_rr_started) begin
                        r_rr_last <= '0;
                    end
                end
            end
            if (i_cmd.rr_take) begin
                r_rr_last <= PORT_W'(rem_val);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item    <= i_in_data;
            r_src_hit <= 1'b0;
            r_dst_hit <= 1'b0;
        end else if (r_rd_pend) begin
            if (rd_key == r_item.src_mac) begin
                r_src_hit <= 1'b1;
            end
            if (rd_key == r_item.dst_mac) begin
                r_dst_hit  <= 1'b1;
                r_dst_port <= rd_port;
            end
        end
        if (i_cmd.update) begin
            r_res <= n_res;
        end else if (i_cmd.rr_take) begin
            r_res.egress_port <= PORT_W'(rem_val);
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_sts.scan_done = (r_scan_cnt == r_fill) && !r_rd_pend;
    assign o_sts.need_rr   = need_rr;
    assign o_sts.rr_done   = !rem_busy;
    assign o_sts.out_busy  = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/mlf_ctrl.sv @@
// Controller state machine: sequences scan, update, round-robin and output load.
// Depends on mlf_pkg.
module mlf_ctrl
    import mlf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_mlf_sts i_sts,
    output t_mlf_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_RR     = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.need_rr ? S_RR : S_OUT;
            end
            S_RR: begin
                if (i_sts.rr_done) begin
                    o_cmd.rr_take = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/mac_learning_forwarder_rr_unit.sv @@
// Top level of the MAC learning forwarder with round-robin ARP probe dispatch.
// Depends on mlf_pkg, mlf_ctrl and mlf_datapath (which holds mlf_ram, mlf_rem_unit).
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data): one packet-in event per
//    transfer. Output channel (o_out_valid / i_out_stall / o_out_data): one
//    forwarding decision per event, in order.
//  - APB port: register 0 (byte address 0) is server_count, 9 bits, reset 4.
//    Write only while the block is idle.
//  - Search: the table is searched one entry per cycle through the table RAM's
//    single read port, fill_count entries per event (fill_count at most 64). An
//    ARP probe after the first adds the bit-serial (last + 1) mod count and a step
//    that takes its result into the egress port.
//  - Events: one at a time; the next transfer is taken the cycle after the result is
//    loaded into the output register, so a stalled receiver does not hold up the
//    next event's search.
//  - Receiver stall: the result holds in the output register; a following
//    result waits in the datapath result register until that one is free.
//  - Reset (synchronous, active low): table empty, round-robin not started,
//    server_count 4. No clearing pass; entries past the fill count are never read.
module mac_learning_forwarder_rr_unit
    import mlf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_mlf_in               i_in_data,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_mlf_out              o_out_data,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_mlf_cmd        cmd;
    t_mlf_sts        sts;
    logic [SC_W-1:0] r_server_count;
    logic            cfg_wr;

    // APB: zero wait states; register index is paddr[2], other bits ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SERVER_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= SC_RESET;
        end else if (cfg_wr) begin
            r_server_count <= pwdata[SC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SERVER_COUNT) ? APB_DATA_W'(r_server_count) : '0;

    mlf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    mlf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_data     (i_in_data),
        .i_server_count(r_server_count),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

`ifndef SYNTHESIS
    // one event at a time: after a transfer the input side is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input transfer taken while an event is in progress");

    // the output register is never overwritten while its result waits
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !sts.out_busy)
        else $error("result loaded over a stalled result");

    a_learn_or_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.learned_new && o_out_data.table_full))
        else $error("learned_new and table_full both set");

    a_flood_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.flood) |-> (o_out_data.egress_port == '0))
        else $error("flood decision with non-zero egress port");
`endif

endmodule

@@ tb/tb_mac_learning_forwarder_rr_unit.sv @@
// Self-checking testbench for the MAC learning forwarder with round-robin ARP dispatch.
// Depends on mlf_pkg and mac_learning_forwarder_rr_unit; predicts every decision itself
// and checks each output transfer against it.
`timescale 1ns / 100ps

module tb_mac_learning_forwarder_rr_unit;
    import mlf_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    // guard against a hung run; set well above the slowest correct run
    localparam int CYCLE_LIMIT  = 1_500_000;
    // longest event: full table search plus the serial remainder, with margin
    localparam int SETTLE       = 100;
    localparam int HOLD_LEN     = 400;
    localparam int POOL_SIZE    = 40;

    localparam logic [APB_ADDR_W-1:0] ADDR_SERVER_COUNT = {REG_SERVER_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED     = APB_ADDR_W'(4);

    localparam logic [MAC_W-1:0] MAC_ZERO   = '0;
    localparam logic [MAC_W-1:0] MAC_HOST_A = 48'h0200_0000_0001;
    localparam logic [MAC_W-1:0] MAC_HIGH   = 48'hFFFF_FFFF_FFFE;
    localparam logic [MAC_W-1:0] MAC_SELF   = 48'h0A0B_0C0D_0E0F;

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_mlf_in               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_mlf_out              out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mac_learning_forwarder_rr_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Forwarding model: our own copy of the learned table, the round-robin
    // pointer and the server count register
    // ------------------------------------------------------------------
    logic [MAC_W-1:0]  fwd_key  [TABLE_DEPTH];
    logic [PORT_W-1:0] fwd_port [TABLE_DEPTH];
    int                fwd_fill = 0;
    logic [PORT_W-1:0] rr_last  = '0;
    bit                rr_on    = 1'b0;
    logic [SC_W-1:0]   sc_model = SC_RESET;

    t_mlf_out          decision_q[$];   // decisions still owed by the DUT
    logic [MAC_W-1:0]  mac_pool[POOL_SIZE];

    int errors     = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_learned  = 0;
    int n_refused  = 0;
    int n_probes   = 0;
    int n_hits     = 0;
    int cycle_count = 0;

    // idling control shared by sender and receiver
    bit no_idle    = 1'b0;
    int stall_left = 0;
    int hold_left  = 0;
    int hold_req   = 0;
    int hold_ack   = 0;

    // table entries past the fill count are never consulted
    function automatic bit find_entry(input logic [MAC_W-1:0] mac, output int slot);
        slot = 0;
        for (int i = 0; i < fwd_fill; i++) begin
            if (fwd_key[i] == mac) begin
                slot = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // learn first, then look up the destination, so it sees a fresh entry
    function automatic t_mlf_out forward_decision(input t_mlf_in ev);
        t_mlf_out d;
        int       slot;
        int       n;
        d       = '0;
        d.flood = 1'b1;
        if (!find_entry(ev.src_mac, slot)) begin
            if (fwd_fill < TABLE_DEPTH) begin
                fwd_key[fwd_fill]  = ev.src_mac;
                fwd_port[fwd_fill] = ev.ingress_port;
                fwd_fill++;
                d.learned_new = 1'b1;
                n_learned++;
            end else begin
                d.table_full = 1'b1;
                n_refused++;
            end
        end
        if (ev.dst_mac != MAC_BCAST) begin
            if (find_entry(ev.dst_mac, slot)) begin
                d.flood       = 1'b0;
                d.egress_port = fwd_port[slot];
                n_hits++;
            end
        end else if (ev.src_ipv4 == '0) begin
            // ARP probe; a zero count behaves as one server
            n = (sc_model == '0) ? 1 : int'(sc_model);
            if (rr_on) begin
                rr_last = PORT_W'((int'(rr_last) + 1) % n);
            end else begin
                rr_last = '0;
                rr_on   = 1'b1;
            end
            d.flood       = 1'b0;
            d.egress_port = rr_last;
            n_probes++;
        end
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly back to back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    function automatic t_mlf_in mk_event(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                                         input logic [PORT_W-1:0] port, input logic [IP_W-1:0] sip);
        t_mlf_in ev;
        ev.src_mac      = src;
        ev.dst_mac      = dst;
        ev.ingress_port = port;
        ev.src_ipv4     = sip;
        return ev;
    endfunction

    function automatic t_mlf_in random_event(input int src_pool_pct, input int probe_pct);
        t_mlf_in ev;
        int      r;
        if ($urandom_range(0, 99) < src_pool_pct)
            ev.src_mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            ev.src_mac = random_mac();
        ev.ingress_port = PORT_W'($urandom());
        ev.src_ipv4     = $urandom();
        r = $urandom_range(0, 99);
        if (r < probe_pct) begin
            ev.dst_mac  = MAC_BCAST;
            ev.src_ipv4 = '0;
        end else if (r < probe_pct + 10) begin
            ev.dst_mac = MAC_BCAST;              // plain broadcast
        end else if (r < probe_pct + 20) begin
            ev.dst_mac = random_mac();           // almost surely unknown
        end else if (r < probe_pct + 25) begin
            ev.dst_mac = ev.src_mac;
        end else begin
            ev.dst_mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        // zero source IP on a unicast must not touch the round robin
        if (ev.dst_mac != MAC_BCAST && $urandom_range(0, 19) == 0)
            ev.src_ipv4 = '0;
        return ev;
    endfunction

    // one input transfer; valid is left high so back-to-back items never
    // drop it, and drain_decisions lowers it at the end of a burst
    task automatic send_event(input t_mlf_in ev);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        decision_q.push_back(forward_decision(ev));
        n_sent++;
        @(negedge i_clk);
    endtask

    // block idle: input quiet and every owed decision delivered
    task automatic drain_decisions();
        in_valid <= 1'b0;
        while (decision_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // APB setup then access phase; pready is honoured though always high
    task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_server_count();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_SERVER_COUNT, '0, rd);
        if (rd !== APB_DATA_W'(sc_model)) begin
            $error("server_count readback: expected %0d, actual %0d", sc_model, rd);
            errors++;
        end
    endtask

    task automatic set_server_count(input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        drain_decisions();
        apb_access(1'b1, ADDR_SERVER_COUNT, value, rd);
        sc_model = value[SC_W-1:0];
        check_server_count();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall runs, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_LEN - 1;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Checker: every output transfer against the oldest owed decision
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_decisions
        t_mlf_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (decision_q.size() == 0) begin
                $error("decision transfer with none owed: %p", out_data);
                errors++;
            end else begin
                want = decision_q.pop_front();
                n_checked++;
                if (out_data.flood !== want.flood) begin
                    $error("flood: expected %0d, actual %0d", want.flood, out_data.flood);
                    errors++;
                end
                if (out_data.egress_port !== want.egress_port) begin
                    $error("egress_port: expected %0d, actual %0d",
                           want.egress_port, out_data.egress_port);
                    errors++;
                end
                if (out_data.learned_new !== want.learned_new) begin
                    $error("learned_new: expected %0d, actual %0d",
                           want.learned_new, out_data.learned_new);
                    errors++;
                end
                if (out_data.table_full !== want.table_full) begin
                    $error("table_full: expected %0d, actual %0d",
                           want.table_full, out_data.table_full);
                    errors++;
                end
            end
        end
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mac_learning_forwarder_rr_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // learning, no overwrite, unicast hit and miss, broadcast source, src == dst
    task automatic test_learning();
        send_event(mk_event(MAC_ZERO,   MAC_HOST_A, 16'h0000, 32'hFFFF_FFFF));
        send_event(mk_event(MAC_HOST_A, MAC_ZERO,   16'hFFFF, 32'h0A00_0001));
        send_event(mk_event(MAC_HIGH,   MAC_HOST_A, 16'h1234, 32'h8000_0000));
        send_event(mk_event(MAC_HOST_A, MAC_HIGH,   16'h0001, 32'h0000_0001));
        send_event(mk_event(MAC_BCAST,  MAC_BCAST,  16'h00AA, 32'hFFFF_FFFF));
        send_event(mk_event(MAC_SELF,   MAC_SELF,   16'h0BEE, 32'h0000_0000));
        drain_decisions();
    endtask

    // first probe, wrap-around, zero and out-of-range counts, unmapped register
    task automatic test_round_robin();
        logic [APB_DATA_W-1:0] rd;
        send_event(mk_event(MAC_HOST_A, MAC_BCAST, 16'h0007, '0));
        send_event(mk_event(MAC_HOST_A, MAC_BCAST, 16'h0007, '0));
        send_event(mk_event(MAC_HIGH,   MAC_BCAST, 16'h0007, 32'hC0A8_0001));
        send_event(mk_event(MAC_HOST_A, MAC_BCAST, 16'h0007, '0));
        set_server_count(32'd2);
        repeat (3) send_event(mk_event(MAC_SELF, MAC_BCAST, 16'h0003, '0));
        set_server_count(32'd0);
        repeat (2) send_event(mk_event(MAC_SELF, MAC_BCAST, 16'h0003, '0));
        // upper bits of the write data are dropped, leaving 511
        set_server_count(32'hFFFF_FFFF);
        repeat (2) send_event(mk_event(MAC_ZERO, MAC_BCAST, 16'h0003, '0));
        drain_decisions();
        apb_access(1'b1, ADDR_UNMAPPED, 32'd7, rd);
        check_server_count();
        set_server_count(32'd257);
        send_event(mk_event(MAC_ZERO, MAC_BCAST, 16'h0003, '0));
        set_server_count(32'd1);
        send_event(mk_event(MAC_ZERO, MAC_BCAST, 16'h0003, '0));
        drain_decisions();
    endtask

    task automatic test_random_traffic(input int count, input int src_pool_pct,
                                       input int probe_pct);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0)
                no_idle = ($urandom_range(0, 4) == 0);
            send_event(random_event(src_pool_pct, probe_pct));
        end
        no_idle = 1'b0;
        drain_decisions();
    endtask

    // fresh sources until the table is full, then some it must refuse
    task automatic test_table_fill();
        while (fwd_fill < TABLE_DEPTH)
            send_event(mk_event(random_mac(), mac_pool[$urandom_range(0, POOL_SIZE - 1)],
                                PORT_W'($urandom()), $urandom()));
        repeat (20)
            send_event(mk_event(random_mac(), fwd_key[$urandom_range(0, TABLE_DEPTH - 1)],
                                PORT_W'($urandom()), $urandom()));
        drain_decisions();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_req++;
        repeat (16) send_event(random_event(70, 30));
        no_idle = 1'b0;
        drain_decisions();
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++)
            mac_pool[i] = random_mac();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_learning();
        test_round_robin();

        // table still has room: sources only from the pool
        set_server_count(32'd3);
        test_random_traffic(250, 100, 20);
        set_server_count(32'd4);
        test_random_traffic(150, 100, 30);
        test_table_fill();
        test_backpressure();

        // full table from here on; long probe run wraps a 256-port count
        set_server_count(32'd256);
        test_random_traffic(600, 70, 45);
        set_server_count(32'd1);
        test_random_traffic(80, 70, 30);
        set_server_count(32'd511);
        test_random_traffic(80, 70, 30);
        set_server_count(32'd0);
        test_random_traffic(40, 70, 30);

        drain_decisions();
        repeat (SETTLE) @(negedge i_clk);
        if (decision_q.size() != 0) begin
            $error("%0d decisions never delivered", decision_q.size());
            errors++;
        end

        $display("covered %0d events, %0d decisions checked: %0d sources learned, %0d refused",
                 n_sent, n_checked, n_learned, n_refused);
        $display("%0d ARP probe dispatches, %0d unicast hits, server counts from 0 to 511",
                 n_probes, n_hits);
        if (errors == 0) begin
            $display("mac_learning_forwarder_rr_unit: match");
        end else begin
            $display("mac_learning_forwarder_rr_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/mlf_pkg.sv
src/mlf_ram.sv
src/mlf_rem_unit.sv
src/mlf_datapath.sv
src/mlf_ctrl.sv
src/mac_learning_forwarder_rr_unit.sv
tb/tb_mac_learning_forwarder_rr_unit.sv
